@@ hdl/mbtf_pkg.sv @@
// shared types and constants for the modbus tcp request framer
`timescale 1ns / 1ps

package mbtf_pkg;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	localparam logic OP_HEADER = 1'b0;
	localparam logic OP_DATA   = 1'b1;

	localparam logic [6:0] FC_RD_COILS      = 7'd1;
	localparam logic [6:0] FC_RD_INPUTS     = 7'd2;
	localparam logic [6:0] FC_RD_HOLDING    = 7'd3;
	localparam logic [6:0] FC_RD_INPUT_REGS = 7'd4;
	localparam logic [6:0] FC_WR_COIL       = 7'd5;
	localparam logic [6:0] FC_WR_REG        = 7'd6;
	localparam logic [6:0] FC_WR_COILS      = 7'd15;
	localparam logic [6:0] FC_WR_REGS       = 7'd16;

	localparam logic [10:0] MAX_REGS  = 11'd123;
	localparam logic [10:0] MAX_COILS = 11'd1968;

	localparam logic [7:0] LEN_SHORT      = 8'd6;
	localparam logic [7:0] LEN_MULTI_BASE = 8'd7;

	localparam logic       CFG_TID  = 1'b0;
	localparam logic       CFG_UNIT = 1'b1;

	// header byte positions
	localparam logic [3:0] HB_TID_HI  = 4'd0;
	localparam logic [3:0] HB_TID_LO  = 4'd1;
	localparam logic [3:0] HB_PROT_HI = 4'd2;
	localparam logic [3:0] HB_PROT_LO = 4'd3;
	localparam logic [3:0] HB_LEN_HI  = 4'd4;
	localparam logic [3:0] HB_LEN_LO  = 4'd5;
	localparam logic [3:0] HB_UNIT    = 4'd6;
	localparam logic [3:0] HB_FC      = 4'd7;
	localparam logic [3:0] HB_ADDR_HI = 4'd8;
	localparam logic [3:0] HB_ADDR_LO = 4'd9;
	localparam logic [3:0] HB_WORD_HI = 4'd10;
	localparam logic [3:0] HB_WORD_LO = 4'd11;
	localparam logic [3:0] HB_COUNT   = 4'd12;

	typedef enum logic [1:0] {
		KIND_IDLE,
		KIND_REGS,
		KIND_COILS
	} kind_t;

	typedef enum logic [1:0] {
		JOB_HEAD,
		JOB_REG,
		JOB_BYTE,
		JOB_ERR
	} job_kind_t;

	typedef struct packed {
		job_kind_t   kind;
		logic        multi;
		logic        last;
		logic [6:0]  fc;
		logic [15:0] addr;
		logic [15:0] word;
		logic [7:0]  cnt;
	} job_t;

endpackage

@@ hdl/mbtf_req_if.sv @@
// request channel interface
`timescale 1ns / 1ps

interface mbtf_req_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [6:0]  fcode;
	logic [15:0] address;
	logic [10:0] quantity;
	logic [15:0] value;

	modport source (
		output valid, operation, fcode, address, quantity, value,
		input  ready
	);
	modport sink (
		input  valid, operation, fcode, address, quantity, value,
		output ready
	);
endinterface

@@ hdl/mbtf_frm_if.sv @@
// frame byte channel interface
`timescale 1ns / 1ps

interface mbtf_frm_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       last;
	logic       error;

	modport source (
		output valid, frame_byte, last, error,
		input  ready
	);
	modport sink (
		input  valid, frame_byte, last, error,
		output ready
	);
endinterface

@@ hdl/mbtf_front.sv @@
// front end: accepts requests, tracks open writes, issues serializer jobs
`timescale 1ns / 1ps

module mbtf_front (
	input  logic          clk,
	input  logic          arst_n,
	mbtf_req_if.sink      req,
	input  logic          q_full,
	output logic          q_push,
	output mbtf_pkg::job_t q_data
);
	import mbtf_pkg::*;

	kind_t       kind_q, kind_d;
	logic [10:0] rem_q, rem_d;
	logic [7:0]  acc_q, acc_d;
	logic [2:0]  bit_q, bit_d;

	logic        accept;
	logic [10:0] rem_dec;
	logic [7:0]  acc_or;
	logic [2:0]  bit_inc;
	logic        coil_emit;
	logic        regs_ok;
	logic        coils_ok;
	logic [10:0] qty_plus;
	logic [7:0]  coil_bytes;
	logic [7:0]  reg_bytes;
	logic        job_valid;

	assign req.ready  = !q_full;
	assign accept     = req.valid && req.ready;
	assign rem_dec    = rem_q - 11'd1;
	assign acc_or     = acc_q | (8'(req.value[0]) << bit_q);
	assign bit_inc    = bit_q + 3'd1;
	assign coil_emit  = (bit_inc == 3'd0) || (rem_dec == 11'd0);
	assign regs_ok    = (req.quantity != 11'd0) && (req.quantity <= MAX_REGS);
	assign coils_ok   = (req.quantity != 11'd0) && (req.quantity <= MAX_COILS);
	assign qty_plus   = req.quantity + 11'd7;
	assign coil_bytes = qty_plus[10:3];
	assign reg_bytes  = {req.quantity[6:0], 1'b0};
	assign q_push     = accept && job_valid;

	// next state
	always_comb begin
		kind_d = kind_q;
		rem_d  = rem_q;
		acc_d  = acc_q;
		bit_d  = bit_q;
		if (accept) begin
			if (req.operation == OP_DATA) begin
				if (kind_q != KIND_IDLE && rem_q != 11'd0) begin
					rem_d = rem_dec;
					if (rem_dec == 11'd0) begin
						kind_d = KIND_IDLE;
					end
					if (kind_q == KIND_COILS) begin
						if (coil_emit) begin
							acc_d = 8'd0;
							bit_d = 3'd0;
						end else begin
							acc_d = acc_or;
							bit_d = bit_inc;
						end
					end
				end
			end else begin
				kind_d = KIND_IDLE;
				rem_d  = 11'd0;
				acc_d  = 8'd0;
				bit_d  = 3'd0;
				if (req.fcode == FC_WR_REGS && regs_ok) begin
					kind_d = KIND_REGS;
					rem_d  = req.quantity;
				end else if (req.fcode == FC_WR_COILS && coils_ok) begin
					kind_d = KIND_COILS;
					rem_d  = req.quantity;
				end
			end
		end
	end

	// job generation
	always_comb begin
		job_valid    = 1'b0;
		q_data       = '0;
		q_data.kind  = JOB_ERR;
		q_data.fc    = req.fcode;
		q_data.addr  = req.address;
		if (req.operation == OP_DATA) begin
			if (kind_q == KIND_REGS && rem_q != 11'd0) begin
				job_valid    = 1'b1;
				q_data.kind  = JOB_REG;
				q_data.word  = req.value;
				q_data.last  = (rem_dec == 11'd0);
			end else if (kind_q == KIND_COILS && rem_q != 11'd0) begin
				job_valid    = coil_emit;
				q_data.kind  = JOB_BYTE;
				q_data.word  = {8'd0, acc_or};
				q_data.last  = (rem_dec == 11'd0);
			end
		end else begin
			job_valid = 1'b1;
			unique case (req.fcode) inside
				FC_RD_COILS, FC_RD_INPUTS, FC_RD_HOLDING, FC_RD_INPUT_REGS: begin
					q_data.kind = JOB_HEAD;
					q_data.word = {5'd0, req.quantity};
				end
				FC_WR_COIL, FC_WR_REG: begin
					q_data.kind = JOB_HEAD;
					q_data.word = req.value;
				end
				FC_WR_REGS: begin
					if (regs_ok) begin
						q_data.kind  = JOB_HEAD;
						q_data.multi = 1'b1;
						q_data.word  = {5'd0, req.quantity};
						q_data.cnt   = reg_bytes;
					end
				end
				FC_WR_COILS: begin
					if (coils_ok) begin
						q_data.kind  = JOB_HEAD;
						q_data.multi = 1'b1;
						q_data.word  = {5'd0, req.quantity};
						q_data.cnt   = coil_bytes;
					end
				end
				default: q_data.kind = JOB_ERR;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_IDLE;
			rem_q  <= 11'd0;
			acc_q  <= 8'd0;
			bit_q  <= 3'd0;
		end else begin
			kind_q <= kind_d;
			rem_q  <= rem_d;
			acc_q  <= acc_d;
			bit_q  <= bit_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(kind_q != KIND_IDLE) |-> (rem_q != 11'd0))
		else $error("open write with nothing left to collect");
	assert property (@(posedge clk) disable iff (!arst_n)
		(kind_q != KIND_COILS) |-> (acc_q == 8'd0 && bit_q == 3'd0))
		else $error("coil packing state left over outside a coil write");

endmodule

@@ hdl/mbtf_fifo.sv @@
// small job queue between front end and serializer
`timescale 1ns / 1ps

module mbtf_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mbtf_pkg::job_t push_data,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output mbtf_pkg::job_t head
);
	import mbtf_pkg::*;

	job_t           mem [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;
	logic           do_push;
	logic           do_pop;

	assign full       = (count_q == (QAW + 1)'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (QAW + 1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (QAW + 1)'(1);
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QAW + 1)'(QDEPTH))
		else $error("job queue overfilled");
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || count_q == (QAW + 1)'(QDEPTH)) |-> (wr_ptr_q == rd_ptr_q))
		else $error("job queue pointers out of step with count");

endmodule

@@ hdl/mbtf_back.sv @@
// serializer: turns queued jobs into frame bytes, one per cycle unless stalled
`timescale 1ns / 1ps

module mbtf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [15:0]    transaction_id,
	input  logic [7:0]     unit_id,
	input  logic           head_valid,
	input  mbtf_pkg::job_t head,
	output logic           pop,
	mbtf_frm_if.source     frame
);
	import mbtf_pkg::*;

	logic [3:0] idx_q;
	logic [3:0] end_idx;
	logic       load;
	logic       at_end;
	logic [7:0] len;
	logic [7:0] byte_d;
	logic       last_d;
	logic       err_d;

	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       err_q;

	assign load   = head_valid && (!valid_q || frame.ready);
	assign at_end = (idx_q == end_idx);
	assign pop    = load && at_end;
	assign len    = head.multi ? (LEN_MULTI_BASE + head.cnt) : LEN_SHORT;

	always_comb begin
		end_idx = 4'd0;
		byte_d  = 8'd0;
		last_d  = 1'b0;
		err_d   = 1'b0;
		unique case (head.kind)
			JOB_HEAD: begin
				end_idx = head.multi ? HB_COUNT : HB_WORD_LO;
				last_d  = at_end && !head.multi;
				unique case (idx_q)
					HB_TID_HI:  byte_d = transaction_id[15:8];
					HB_TID_LO:  byte_d = transaction_id[7:0];
					HB_PROT_HI: byte_d = 8'd0;
					HB_PROT_LO: byte_d = 8'd0;
					HB_LEN_HI:  byte_d = 8'd0;
					HB_LEN_LO:  byte_d = len;
					HB_UNIT:    byte_d = unit_id;
					HB_FC:      byte_d = {1'b0, head.fc};
					HB_ADDR_HI: byte_d = head.addr[15:8];
					HB_ADDR_LO: byte_d = head.addr[7:0];
					HB_WORD_HI: byte_d = head.word[15:8];
					HB_WORD_LO: byte_d = head.word[7:0];
					HB_COUNT:   byte_d = head.cnt;
					default:    byte_d = 8'd0;
				endcase
			end
			JOB_REG: begin
				end_idx = 4'd1;
				byte_d  = at_end ? head.word[7:0] : head.word[15:8];
				last_d  = at_end && head.last;
			end
			JOB_BYTE: begin
				byte_d = head.word[7:0];
				last_d = head.last;
			end
			JOB_ERR: begin
				last_d = 1'b1;
				err_d  = 1'b1;
			end
			default: begin
				last_d = 1'b1;
				err_d  = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 4'd0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= at_end ? 4'd0 : idx_q + 4'd1;
			end
			if (load) begin
				valid_q <= 1'b1;
			end else if (frame.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= byte_d;
			last_q <= last_d;
			err_q  <= err_d;
		end
	end

	assign frame.valid      = valid_q;
	assign frame.frame_byte = byte_q;
	assign frame.last       = last_q;
	assign frame.error      = err_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && err_q) |-> last_q)
		else $error("error request not marked last");
	assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= HB_COUNT)
		else $error("serializer byte index past the longest header");

endmodule

@@ hdl/modbus_tcp_request_framer.sv @@
// top level of the modbus tcp request framer
//
//  channel  dir  handshake      payload
//  req      in   valid/ready    operation, fcode, address, quantity, value
//  frame    out  valid/ready    frame_byte, last, error
//  cfg      in   cfg_wr_en      cfg_index (0 transaction id, 1 unit id), cfg_data
//
//  while the sink is ready, one frame byte leaves per cycle from the serializer
//  output register; a read or single write header gives 12 bytes, a multi write
//  header 13, a register data request 2, a coil data request 1 or none
//  a four-entry job queue decouples the front end from the serializer
//  reset clears the open-write state, queue and output; unit id resets to 1
`timescale 1ns / 1ps

module modbus_tcp_request_framer (
	input  logic        clk,
	input  logic        arst_n,
	mbtf_req_if.sink    req,
	mbtf_frm_if.source  frame,
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	import mbtf_pkg::*;

	logic [15:0] transaction_id_q;
	logic [7:0]  unit_id_q;

	logic        q_full;
	logic        q_push;
	job_t        q_data;
	logic        q_pop;
	logic        q_head_valid;
	job_t        q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			transaction_id_q <= 16'd0;
			unit_id_q        <= 8'd1;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_TID:  transaction_id_q <= cfg_data;
				CFG_UNIT: unit_id_q        <= cfg_data[7:0];
				default:  unit_id_q        <= unit_id_q;
			endcase
		end
	end

	mbtf_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.q_full (q_full),
		.q_push (q_push),
		.q_data (q_data)
	);

	mbtf_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_data),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head       (q_head)
	);

	mbtf_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.transaction_id (transaction_id_q),
		.unit_id        (unit_id_q),
		.head_valid     (q_head_valid),
		.head           (q_head),
		.pop            (q_pop),
		.frame          (frame)
	);

endmodule

@@ tb/tb_modbus_tcp_request_framer.sv @@
// self-checking testbench for the modbus tcp request framer with random traffic and stalls
`timescale 1ns / 1ps

module tb_modbus_tcp_request_framer;
	import mbtf_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 40;
	localparam int RX_HOLD_CYCLES = 300;

	localparam logic [6:0]  FC_NONE = 7'd0;
	localparam logic [6:0]  FC_MAX  = 7'h7F;
	localparam logic [10:0] QTY_TOP = 11'h7FF;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       err;
	} frame_byte_t;

	typedef enum int {
		RX_ALWAYS,
		RX_COIN,
		RX_MOSTLY,
		RX_PERIODIC
	} rx_style_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic        cfg_index;
	logic [15:0] cfg_data;

	mbtf_req_if req_ch ();
	mbtf_frm_if frm_ch ();

	modbus_tcp_request_framer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.frame     (frm_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// framer state as it should be
	logic [15:0] cur_tid    = 16'h0000;
	logic [7:0]  cur_unit   = 8'h01;
	kind_t       open_kind  = KIND_IDLE;
	logic [10:0] data_left  = '0;
	logic [7:0]  coil_pack  = '0;
	logic [2:0]  coil_pos   = '0;

	frame_byte_t frame_bytes_due [$];
	frame_byte_t due_byte;

	int fail_count    = 0;
	int requests_seen = 0;
	int bytes_checked = 0;
	int frames_seen   = 0;
	int rejects_seen  = 0;
	int reg_writes    = 0;
	int stall_cycles  = 0;

	bit pacing_on = 1'b1;
	int burst_left = 0;

	rx_style_t rx_style = RX_ALWAYS;
	int rx_style_left = 0;
	int rx_hold_left  = 0;
	int rx_hold_reqs  = 0;
	int rx_hold_seen  = 0;
	int rx_cyc        = 0;

	function void owe_byte(input logic [7:0] b, input logic l, input logic e);
		frame_bytes_due.push_back({b, l, e});
	endfunction

	function void owe_head(input logic [15:0] len, input logic [6:0] fc,
		input logic [15:0] addr);
		owe_byte(cur_tid[15:8], 1'b0, 1'b0);
		owe_byte(cur_tid[7:0], 1'b0, 1'b0);
		owe_byte(8'h00, 1'b0, 1'b0);
		owe_byte(8'h00, 1'b0, 1'b0);
		owe_byte(len[15:8], 1'b0, 1'b0);
		owe_byte(len[7:0], 1'b0, 1'b0);
		owe_byte(cur_unit, 1'b0, 1'b0);
		owe_byte({1'b0, fc}, 1'b0, 1'b0);
		owe_byte(addr[15:8], 1'b0, 1'b0);
		owe_byte(addr[7:0], 1'b0, 1'b0);
	endfunction

	// bytes that one accepted request adds to the frame stream
	function void frame_request(input logic op, input logic [6:0] fc, input logic [15:0] addr,
		input logic [10:0] qty, input logic [15:0] val);
		int          nbytes;
		logic [15:0] len;
		logic [15:0] qword;
		logic [7:0]  cnt;
		qword = {5'b0, qty};
		if (op == OP_DATA) begin
			if (open_kind == KIND_REGS && data_left != 0) begin
				data_left = data_left - 11'd1;
				owe_byte(val[15:8], 1'b0, 1'b0);
				owe_byte(val[7:0], data_left == 0, 1'b0);
				if (data_left == 0)
					open_kind = KIND_IDLE;
			end else if (open_kind == KIND_COILS && data_left != 0) begin
				data_left = data_left - 11'd1;
				coil_pack[coil_pos] = val[0];
				coil_pos = coil_pos + 3'd1;
				if (coil_pos == 0 || data_left == 0) begin
					owe_byte(coil_pack, data_left == 0, 1'b0);
					if (data_left == 0)
						open_kind = KIND_IDLE;
					coil_pack = '0;
					coil_pos = '0;
				end
			end
			return;
		end
		open_kind = KIND_IDLE;
		data_left = '0;
		coil_pack = '0;
		coil_pos = '0;
		case (fc)
			FC_RD_COILS, FC_RD_INPUTS, FC_RD_HOLDING, FC_RD_INPUT_REGS: begin
				owe_head({8'h00, LEN_SHORT}, fc, addr);
				owe_byte(qword[15:8], 1'b0, 1'b0);
				owe_byte(qword[7:0], 1'b1, 1'b0);
			end
			FC_WR_COIL, FC_WR_REG: begin
				owe_head({8'h00, LEN_SHORT}, fc, addr);
				owe_byte(val[15:8], 1'b0, 1'b0);
				owe_byte(val[7:0], 1'b1, 1'b0);
			end
			FC_WR_REGS: begin
				if (qty >= 1 && qty <= MAX_REGS) begin
					len = 16'(LEN_MULTI_BASE + 2 * qty);
					cnt = 8'(2 * qty);
					owe_head(len, fc, addr);
					owe_byte(qword[15:8], 1'b0, 1'b0);
					owe_byte(qword[7:0], 1'b0, 1'b0);
					owe_byte(cnt, 1'b0, 1'b0);
					open_kind = KIND_REGS;
					data_left = qty;
				end else begin
					owe_byte(8'h00, 1'b1, 1'b1);
				end
			end
			FC_WR_COILS: begin
				if (qty >= 1 && qty <= MAX_COILS) begin
					nbytes = (qty + 7) / 8;
					len = 16'(LEN_MULTI_BASE + nbytes);
					owe_head(len, fc, addr);
					owe_byte(qword[15:8], 1'b0, 1'b0);
					owe_byte(qword[7:0], 1'b0, 1'b0);
					owe_byte(8'(nbytes), 1'b0, 1'b0);
					open_kind = KIND_COILS;
					data_left = qty;
				end else begin
					owe_byte(8'h00, 1'b1, 1'b1);
				end
			end
			default: owe_byte(8'h00, 1'b1, 1'b1);
		endcase
	endfunction

	// predict on accepted requests, check every accepted frame byte
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wr_en) begin
				if (cfg_index == CFG_TID)
					cur_tid = cfg_data;
				else
					cur_unit = cfg_data[7:0];
			end
			if (req_ch.valid && req_ch.ready) begin
				requests_seen++;
				frame_request(req_ch.operation, req_ch.fcode, req_ch.address,
					req_ch.quantity, req_ch.value);
			end
			if (frm_ch.valid && frm_ch.ready) begin
				bytes_checked++;
				if (frm_ch.last && !frm_ch.error)
					frames_seen++;
				if (frm_ch.error)
					rejects_seen++;
				if (frame_bytes_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: unexpected frame byte %02h last %0b error %0b", $realtime,
							frm_ch.frame_byte, frm_ch.last, frm_ch.error);
				end else begin
					due_byte = frame_bytes_due.pop_front();
					if (frm_ch.frame_byte !== due_byte.data || frm_ch.last !== due_byte.last ||
						frm_ch.error !== due_byte.err) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: byte %0d expected %02h last %0b error %0b, got %02h last %0b error %0b",
								$realtime, bytes_checked, due_byte.data, due_byte.last,
								due_byte.err, frm_ch.frame_byte, frm_ch.last, frm_ch.error);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (frm_ch.valid && frm_ch.ready) ||
			cfg_wr_en) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// frame sink: changing stall styles plus an occasional long hold-off
	always @(negedge clk) begin
		rx_cyc++;
		if (rx_hold_seen != rx_hold_reqs) begin
			rx_hold_seen = rx_hold_reqs;
			rx_hold_left = RX_HOLD_CYCLES;
		end
		if (rx_style_left == 0) begin
			rx_style = rx_style_t'($urandom_range(0, 3));
			rx_style_left = $urandom_range(32, 256);
		end else begin
			rx_style_left--;
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			frm_ch.ready <= 1'b0;
		end else begin
			case (rx_style)
				RX_ALWAYS: frm_ch.ready <= 1'b1;
				RX_COIN:   frm_ch.ready <= 1'($urandom_range(0, 1));
				RX_MOSTLY: frm_ch.ready <= ($urandom_range(0, 7) != 0);
				default:   frm_ch.ready <= ((rx_cyc % 5) < 3);
			endcase
		end
	end

	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 3);
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 100) :
				$urandom_range(0, 8);
		end
	endtask

	task automatic send_req(input logic op, input logic [6:0] fc, input logic [15:0] addr,
		input logic [10:0] qty, input logic [15:0] val);
		req_ch.valid <= 1'b1;
		req_ch.operation <= op;
		req_ch.fcode <= fc;
		req_ch.address <= addr;
		req_ch.quantity <= qty;
		req_ch.value <= val;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		@(negedge clk);
		if (pacing_on)
			pace();
	endtask

	task automatic send_data(input logic [15:0] val);
		send_req(OP_DATA, 7'($urandom), 16'($urandom), 11'($urandom), val);
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		while (frame_bytes_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_register(input logic idx, input logic [15:0] data);
		drain();
		cfg_index <= idx;
		cfg_data <= data;
		cfg_wr_en <= 1'b1;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		reg_writes++;
		@(negedge clk);
	endtask

	task automatic run_traffic(input int n_items);
		int         sent;
		int         pick;
		int         qty;
		int         ndata;
		logic [6:0] fc;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				fc = 7'($urandom_range(FC_RD_COILS, FC_WR_REG));
				send_req(OP_HEADER, fc, 16'($urandom), 11'($urandom), 16'($urandom));
				sent++;
			end else if (pick < 80) begin
				fc = (pick < 55) ? FC_WR_REGS : FC_WR_COILS;
				if (fc == FC_WR_REGS)
					qty = ($urandom_range(0, 15) == 0) ? $urandom_range(1, MAX_REGS) :
						$urandom_range(1, 6);
				else
					qty = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 200) :
						$urandom_range(1, 20);
				ndata = ($urandom_range(0, 9) == 0) ? $urandom_range(0, qty - 1) : qty;
				if (ndata > n_items - sent - 1)
					ndata = n_items - sent - 1;
				send_req(OP_HEADER, fc, 16'($urandom), 11'(qty), 16'($urandom));
				repeat (ndata) send_data(16'($urandom));
				sent += 1 + ndata;
			end else if (pick < 90) begin
				case ($urandom_range(0, 3))
					0: send_req(OP_HEADER, 7'($urandom_range(FC_WR_REG + 1, FC_WR_COILS - 1)),
						16'($urandom), 11'($urandom), 16'($urandom));
					1: send_req(OP_HEADER, FC_WR_REGS, 16'($urandom),
						($urandom_range(0, 1) == 0) ? 11'd0 :
						11'($urandom_range(MAX_REGS + 1, QTY_TOP)), 16'($urandom));
					2: send_req(OP_HEADER, FC_WR_COILS, 16'($urandom),
						($urandom_range(0, 1) == 0) ? 11'd0 :
						11'($urandom_range(MAX_COILS + 1, QTY_TOP)), 16'($urandom));
					default: send_req(OP_HEADER, 7'($urandom_range(FC_WR_REGS + 1, FC_MAX)),
						16'($urandom), 11'($urandom), 16'($urandom));
				endcase
				sent++;
			end else begin
				send_req(1'($urandom_range(0, 1)), 7'($urandom), 16'($urandom),
					11'($urandom), 16'($urandom));
				sent++;
			end
			if ($urandom_range(0, 49) == 0)
				drain();
		end
	endtask

	// every read and single write code under reset register values
	task automatic test_single_frames();
		send_req(OP_HEADER, FC_RD_COILS, 16'h0000, 11'd0, 16'h0000);
		send_req(OP_HEADER, FC_RD_INPUTS, 16'hFFFF, QTY_TOP, 16'hFFFF);
		send_req(OP_HEADER, FC_RD_HOLDING, 16'h1234, 11'd125, 16'h5A5A);
		send_req(OP_HEADER, FC_RD_INPUT_REGS, 16'h8000, 11'd1, 16'h0000);
		send_req(OP_HEADER, FC_WR_COIL, 16'h0013, 11'd0, 16'hFF00);
		send_req(OP_HEADER, FC_WR_REG, 16'hFFFF, QTY_TOP, 16'hFFFF);
		drain();
	endtask

	// unknown codes, write quantities outside the limits, data with no open write
	task automatic test_rejects();
		send_req(OP_HEADER, FC_NONE, 16'h0001, 11'd1, 16'h0001);
		send_req(OP_HEADER, FC_MAX, 16'hFFFF, QTY_TOP, 16'hFFFF);
		send_req(OP_HEADER, FC_WR_REGS, 16'h0010, 11'd0, 16'h0000);
		send_req(OP_HEADER, FC_WR_REGS, 16'h0010, MAX_REGS + 11'd1, 16'h0000);
		send_req(OP_HEADER, FC_WR_COILS, 16'h0020, 11'd0, 16'h0000);
		send_req(OP_HEADER, FC_WR_COILS, 16'h0020, MAX_COILS + 11'd1, 16'h0000);
		send_data(16'hFFFF);
		drain();
	endtask

	// register write, coil write across a byte boundary, abandoned write
	task automatic test_write_sequences();
		logic [8:0] coil_bits;
		coil_bits = 9'b1_1100_1101;
		send_req(OP_HEADER, FC_WR_REGS, 16'h0100, 11'd2, 16'h0000);
		send_data(16'h0000);
		send_data(16'hFFFF);
		send_req(OP_HEADER, FC_WR_COILS, 16'h0200, 11'd9, 16'h0000);
		for (int i = 0; i < 9; i++)
			send_data({15'($urandom), coil_bits[i]});
		send_req(OP_HEADER, FC_WR_REGS, 16'h0300, 11'd3, 16'h0000);
		send_data(16'hBEEF);
		send_req(OP_HEADER, FC_RD_HOLDING, 16'h0300, 11'd3, 16'h0000);
		drain();
	endtask

	// traffic under several register settings, extremes included
	task automatic test_config_sweep();
		set_register(CFG_TID, 16'hFFFF);
		set_register(CFG_UNIT, 16'h00FF);
		run_traffic(20);
		set_register(CFG_TID, 16'h0000);
		set_register(CFG_UNIT, 16'h0000);
		run_traffic(20);
		set_register(CFG_TID, 16'($urandom));
		set_register(CFG_UNIT, 16'($urandom));
		run_traffic(20);
		set_register(CFG_TID, 16'h8001);
		set_register(CFG_UNIT, 16'h0080);
		run_traffic(20);
		drain();
	endtask

	// sink holds off while requests keep coming so the framer fills up
	task automatic test_backpressure();
		pacing_on = 1'b0;
		rx_hold_reqs++;
		for (int i = 0; i < 16; i++)
			send_req(OP_HEADER, 7'($urandom_range(FC_RD_COILS, FC_WR_REG)), 16'($urandom),
				11'($urandom), 16'($urandom));
		send_req(OP_HEADER, FC_WR_REGS, 16'($urandom), 11'd3, 16'h0000);
		repeat (3) send_data(16'($urandom));
		pacing_on = 1'b1;
		drain();
	endtask

	// largest accepted write quantities, each cut short by the next header
	task automatic test_longest_writes();
		send_req(OP_HEADER, FC_WR_REGS, 16'hFFFF, MAX_REGS, 16'h0000);
		repeat (8) send_data(16'($urandom));
		send_req(OP_HEADER, FC_WR_COILS, 16'h0000, MAX_COILS, 16'h0000);
		repeat (12) send_data(16'($urandom));
		send_req(OP_HEADER, FC_RD_COILS, 16'h0000, 11'd8, 16'h0000);
		drain();
	endtask

	task automatic test_random_traffic();
		run_traffic(50);
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.operation = OP_HEADER;
		req_ch.fcode = FC_NONE;
		req_ch.address = '0;
		req_ch.quantity = '0;
		req_ch.value = '0;
		frm_ch.ready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_TID;
		cfg_data = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_single_frames();
		test_rejects();
		test_write_sequences();
		test_config_sweep();
		test_backpressure();
		test_longest_writes();
		test_random_traffic();

		if (frame_bytes_due.size() != 0) begin
			$display("%0d frame bytes never arrived", frame_bytes_due.size());
			fail_count += frame_bytes_due.size();
		end
		$display("run covered %0d requests, %0d frame bytes, %0d full frames, %0d rejects",
			requests_seen, bytes_checked, frames_seen, rejects_seen);
		$display("%0d register writes, %0d failures", reg_writes, fail_count);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/mbtf_pkg.sv
hdl/mbtf_req_if.sv
hdl/mbtf_frm_if.sv
hdl/mbtf_front.sv
hdl/mbtf_fifo.sv
hdl/mbtf_back.sv
hdl/modbus_tcp_request_framer.sv
tb/tb_modbus_tcp_request_framer.sv
